// File: rtl/core/lzwc_pkg.sv
// Package with the command and status bundles shared by the LZW controller and datapath.
`timescale 1ns / 1ps

package lzwc_pkg;

  // End-of-stream code and first dictionary code
  localparam int END_CODE   = 256;
  localparam int FIRST_FREE = 257;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;      // input transaction taken
    logic hash_sub;    // one reduction step of the hash
    logic probe_start; // hash done, set index and step
    logic mem_read;    // read dictionary at probe index
    logic probe_next;  // advance to next probe slot
    logic hit;         // string grows to found code
    logic miss;        // emit current string, restart from byte
    logic miss_write;  // add new entry at probe index
    logic load_cur;    // load current string code into packer
    logic load_end;    // load end code into packer
    logic emit;        // move one packed byte to output register
    logic emit_last;   // run_last flag for emitted byte
    logic emit_end;    // stream_end flag for emitted byte
    logic flush;       // emit partial byte
    logic clr_start;   // start dictionary clearing pass
    logic clr_step;    // clear one dictionary entry
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic have;
    logic hash_ge;
    logic entry_valid;
    logic entry_match;
    logic tries_last;
    logic room;
    logic cnt_ge8;
    logic cnt_lt16;
    logic cnt_eq8;
    logic cnt_nz;
    logic out_free;
    logic clr_done;
  } status_t;

endpackage

// File: rtl/core/lzw_hashed_compressor.sv
// Top level of the hashed-dictionary LZW compressor.
//
// Input stream (s_*): one raw byte per transaction, s_tlast on the final byte
// of a stream. Output stream (m_*): codes packed MSB first into bytes;
// m_tlast marks the last byte caused by an input, m_tuser the
// final byte of a stream.
// Each byte after the first is hashed with the string code, reduced while
// the hash is TABLE_ENTRIES or more, and probes the dictionary slot by
// slot through one memory read port until a hit, free slot or last try.
// A miss then sends one code of CODE_BITS bits, one output byte per cycle
// while the receiver takes them. On the last byte the block sends the string
// code, the end code and any partial byte, then clears the dictionary one
// entry per cycle, all TABLE_ENTRIES of them, during which s_tready is low.
// Reset starts the same clearing pass. When the receiver stalls, the output
// register holds its byte and the block waits before producing the next.
`timescale 1ns / 1ps

module lzw_hashed_compressor #(
  parameter int CODE_BITS     = 12,
  parameter int TABLE_ENTRIES = 5021
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,  // data_byte
  input  logic       s_tlast,  // stream_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,  // packed_byte
  output logic       m_tlast,  // run_last
  output logic       m_tuser   // stream_end
);

  lzwc_pkg::cmd_t    cmd;
  lzwc_pkg::status_t sts;

  lzwc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lzwc_dp #(
    .CODE_BITS     (CODE_BITS),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast),
    .out_end   (m_tuser)
  );

endmodule

// File: rtl/core/lzwc_ctrl.sv
// Controller state machine for the LZW compressor.
`timescale 1ns / 1ps

module lzwc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_ready,
  input  lzwc_pkg::status_t sts,
  output lzwc_pkg::cmd_t   cmd
);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_HASH  = 4'd2;
  localparam logic [3:0] ST_READ  = 4'd3;
  localparam logic [3:0] ST_CMP   = 4'd4;
  localparam logic [3:0] ST_EMIT  = 4'd5;
  localparam logic [3:0] ST_LOADC = 4'd6;
  localparam logic [3:0] ST_LOADE = 4'd7;
  localparam logic [3:0] ST_FLUSH = 4'd8;

  localparam logic [1:0] PH_MISS = 2'd0;
  localparam logic [1:0] PH_CUR  = 2'd1;
  localparam logic [1:0] PH_END  = 2'd2;

  logic [3:0] state, state_next;
  logic [1:0] phase, phase_next;
  logic       last, last_next;

  assign in_ready = (state == ST_IDLE);

  // Next state and command decode
  always_comb begin
    state_next = state;
    phase_next = phase;
    last_next  = last;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          last_next  = in_last;
          if (sts.have) state_next = ST_HASH;
          else if (in_last) state_next = ST_LOADC;
        end
      end
      ST_HASH: begin
        if (sts.hash_ge) cmd.hash_sub = 1'b1;
        else begin
          cmd.probe_start = 1'b1;
          state_next      = ST_READ;
        end
      end
      ST_READ: begin
        cmd.mem_read = 1'b1;
        state_next   = ST_CMP;
      end
      ST_CMP: begin
        if (!sts.entry_valid) begin
          cmd.miss       = 1'b1;
          cmd.load_cur   = 1'b1;
          cmd.miss_write = sts.room;
          phase_next     = PH_MISS;
          state_next     = ST_EMIT;
        end else if (sts.entry_match) begin
          cmd.hit    = 1'b1;
          state_next = last ? ST_LOADC : ST_IDLE;
        end else if (sts.tries_last) begin
          cmd.miss     = 1'b1;
          cmd.load_cur = 1'b1;
          phase_next   = PH_MISS;
          state_next   = ST_EMIT;
        end else begin
          cmd.probe_next = 1'b1;
          state_next     = ST_READ;
        end
      end
      ST_LOADC: begin
        cmd.load_cur = 1'b1;
        phase_next   = PH_CUR;
        state_next   = ST_EMIT;
      end
      ST_LOADE: begin
        cmd.load_end = 1'b1;
        phase_next   = PH_END;
        state_next   = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.cnt_ge8) begin
          if (sts.out_free) begin
            cmd.emit = 1'b1;
            case (phase)
              PH_MISS: cmd.emit_last = !last && sts.cnt_lt16;
              PH_END: begin
                cmd.emit_last = sts.cnt_eq8;
                cmd.emit_end  = sts.cnt_eq8;
              end
              default: cmd.emit_last = 1'b0;
            endcase
          end
        end else begin
          case (phase)
            PH_MISS: state_next = last ? ST_LOADC : ST_IDLE;
            PH_CUR:  state_next = ST_LOADE;
            default: begin
              if (sts.cnt_nz) state_next = ST_FLUSH;
              else begin
                cmd.clr_start = 1'b1;
                state_next    = ST_CLEAR;
              end
            end
          endcase
        end
      end
      ST_FLUSH: begin
        if (sts.out_free) begin
          cmd.flush     = 1'b1;
          cmd.clr_start = 1'b1;
          state_next    = ST_CLEAR;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      phase <= PH_MISS;
      last  <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      last  <= last_next;
    end
  end

endmodule

// File: rtl/core/lzwc_dp.sv
// Datapath for the LZW compressor: dictionary memory, hash probe, bit packer, output register.
`timescale 1ns / 1ps

module lzwc_dp #(
  parameter int CODE_BITS     = 12,
  parameter int TABLE_ENTRIES = 5021
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        in_byte,
  input  lzwc_pkg::cmd_t    cmd,
  output lzwc_pkg::status_t sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last,
  output logic              out_end
);

  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int TRY_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int NFC_W   = CODE_BITS + 1;
  localparam int LARGEST = (1 << CODE_BITS) - 1;
  localparam int SR_W    = CODE_BITS + 7;
  localparam int CNT_W   = $clog2(CODE_BITS + 8);
  // entry layout: {valid, code, prefix, char}
  localparam int ENT_W   = 1 + 2 * CODE_BITS + 8;

  logic [ENT_W-1:0]     mem [TABLE_ENTRIES];
  logic [ENT_W-1:0]     mem_q;
  logic [IDX_W-1:0]     clr_idx;
  logic [IDX_W-1:0]     idx;
  logic [IDX_W-1:0]     step;
  logic [TRY_W-1:0]     tries;
  logic [CODE_BITS-1:0] hval;
  logic [CODE_BITS-1:0] cur;
  logic                 have;
  logic [7:0]           byte_r;
  logic [NFC_W-1:0]     nfc;
  logic [SR_W-1:0]      sr;
  logic [CNT_W-1:0]     cnt;

  logic                 we;
  logic [IDX_W-1:0]     wa;
  logic [ENT_W-1:0]     wd;
  logic [CODE_BITS-1:0] load_code;
  logic [IDX_W-1:0]     idx_next;
  logic                 ent_valid;
  logic [CODE_BITS-1:0] ent_code;
  logic [CODE_BITS-1:0] ent_prefix;
  logic [7:0]           ent_char;

  assign ent_valid  = mem_q[ENT_W-1];
  assign ent_code   = mem_q[ENT_W-2 -: CODE_BITS];
  assign ent_prefix = mem_q[CODE_BITS+7 -: CODE_BITS];
  assign ent_char   = mem_q[7:0];

  // Status to controller
  always_comb begin
    sts.have        = have;
    sts.hash_ge     = 32'(hval) >= TABLE_ENTRIES;
    sts.entry_valid = ent_valid;
    sts.entry_match = (ent_prefix == cur) && (ent_char == byte_r);
    sts.tries_last  = 32'(tries) == TABLE_ENTRIES - 1;
    sts.room        = 32'(nfc) <= LARGEST;
    sts.cnt_ge8     = cnt >= CNT_W'(8);
    sts.cnt_lt16    = cnt < CNT_W'(16);
    sts.cnt_eq8     = cnt == CNT_W'(8);
    sts.cnt_nz      = cnt != '0;
    sts.out_free    = !out_valid || out_ready;
    sts.clr_done    = 32'(clr_idx) == TABLE_ENTRIES - 1;
  end

  // Dictionary write port: clearing pass or new entry
  always_comb begin
    we = cmd.clr_step || cmd.miss_write;
    wa = cmd.clr_step ? clr_idx : idx;
    wd = cmd.clr_step ? '0 : {1'b1, CODE_BITS'(nfc), cur, byte_r};
  end

  // Next probe slot, wrapping below zero
  always_comb begin
    if (idx >= step) idx_next = idx - step;
    else idx_next = IDX_W'(32'(idx) + TABLE_ENTRIES - 32'(step));
  end

  assign load_code = cmd.load_end ? CODE_BITS'(lzwc_pkg::END_CODE) : cur;

  // Dictionary memory
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (cmd.mem_read) mem_q <= mem[idx];
  end

  // Hash and probe registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_r <= in_byte;
      hval   <= {in_byte, {(CODE_BITS-8){1'b0}}} ^ cur;
    end else if (cmd.hash_sub) begin
      hval <= CODE_BITS'(32'(hval) - TABLE_ENTRIES);
    end
    if (cmd.probe_start) begin
      idx   <= IDX_W'(hval);
      step  <= (hval == '0) ? IDX_W'(1) : IDX_W'(TABLE_ENTRIES - 32'(hval));
      tries <= '0;
    end else if (cmd.probe_next) begin
      idx   <= idx_next;
      tries <= tries + TRY_W'(1);
    end
  end

  // String state, code counter and bit packer
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) begin
      clr_idx <= '0;
      have    <= 1'b0;
      cur     <= '0;
      nfc     <= NFC_W'(lzwc_pkg::FIRST_FREE);
      sr      <= '0;
      cnt     <= '0;
    end else begin
      if (cmd.clr_step) clr_idx <= clr_idx + IDX_W'(1);
      if (cmd.accept && !have) begin
        cur  <= CODE_BITS'(in_byte);
        have <= 1'b1;
      end
      if (cmd.hit) cur <= ent_code;
      if (cmd.miss) cur <= CODE_BITS'(byte_r);
      if (cmd.miss_write) nfc <= nfc + NFC_W'(1);
      if (cmd.load_cur || cmd.load_end) begin
        sr  <= sr | ({load_code, 7'b0} >> cnt);
        cnt <= cnt + CNT_W'(CODE_BITS);
      end else if (cmd.emit) begin
        sr  <= sr << 8;
        cnt <= cnt - CNT_W'(8);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.flush) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit || cmd.flush) begin
      out_byte <= sr[SR_W-1 -: 8];
      out_last <= cmd.emit_last || cmd.flush;
      out_end  <= cmd.emit_end || cmd.flush;
    end
  end

endmodule

// File: tb/lzw_hashed_compressor_chk.sv
// Checker for the LZW compressor: predicts packed bytes and compares them.
`timescale 1ns / 1ps

module lzw_hashed_compressor_chk #(
  parameter int CODE_BITS     = 12,
  parameter int TABLE_ENTRIES = 5021
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tlast,
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,
  input  logic       m_tlast,
  input  logic       m_tuser,
  output int         errors,
  output int         pending
);

  localparam int LARGEST = (1 << CODE_BITS) - 1;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       stream_end;
  } packed_out_t;

  packed_out_t byte_q[$];

  // Predicted dictionary and packer state
  bit        slot_used [TABLE_ENTRIES];
  int        slot_code [TABLE_ENTRIES];
  int        slot_pfx  [TABLE_ENTRIES];
  bit [7:0]  slot_chr  [TABLE_ENTRIES];
  int        free_code;
  int        cur_str;
  bit        in_string;
  bit [7:0]  rack;
  int        rack_pos;
  int        produced;

  function automatic void clear_model();
    for (int i = 0; i < TABLE_ENTRIES; i++) slot_used[i] = 0;
    free_code = lzwc_pkg::FIRST_FREE;
    cur_str   = 0;
    in_string = 0;
    rack      = 0;
    rack_pos  = 0;
  endfunction

  function automatic void push_byte(bit [7:0] b);
    packed_out_t e;
    e.data = b;
    e.run_last = 0;
    e.stream_end = 0;
    byte_q.push_back(e);
    produced++;
  endfunction

  function automatic void pack_code(int code);
    for (int k = CODE_BITS - 1; k >= 0; k--) begin
      if ((code >> k) & 1) rack[7 - rack_pos] = 1'b1;
      rack_pos++;
      if (rack_pos == 8) begin
        push_byte(rack);
        rack = 0;
        rack_pos = 0;
      end
    end
  endfunction

  // 1 hit, 0 free slot, -1 table exhausted
  function automatic int lookup(int pfx, bit [7:0] ch, output int slot);
    int idx;
    int stp;
    idx = ((int'(ch) << (CODE_BITS - 8)) ^ pfx) % TABLE_ENTRIES;
    stp = (idx == 0) ? 1 : TABLE_ENTRIES - idx;
    slot = 0;
    for (int t = 0; t < TABLE_ENTRIES; t++) begin
      if (!slot_used[idx]) begin
        slot = idx;
        return 0;
      end
      if (slot_pfx[idx] == pfx && slot_chr[idx] == ch) begin
        slot = idx;
        return 1;
      end
      if (idx >= stp) idx -= stp;
      else idx = idx + TABLE_ENTRIES - stp;
    end
    return -1;
  endfunction

  function automatic void compress_byte(bit [7:0] b, bit last);
    int slot;
    int r;
    packed_out_t tail;
    produced = 0;
    if (!in_string) begin
      cur_str = b;
      in_string = 1;
    end else begin
      r = lookup(cur_str, b, slot);
      if (r == 1) begin
        cur_str = slot_code[slot];
      end else begin
        if (r == 0 && free_code <= LARGEST) begin
          slot_used[slot] = 1;
          slot_code[slot] = free_code;
          slot_pfx[slot]  = cur_str;
          slot_chr[slot]  = b;
          free_code++;
        end
        pack_code(cur_str);
        cur_str = b;
      end
    end
    if (last) begin
      pack_code(cur_str);
      pack_code(lzwc_pkg::END_CODE);
      if (rack_pos != 0) push_byte(rack);
      clear_model();
    end
    if (produced > 0) begin
      tail = byte_q.pop_back();
      tail.run_last = 1;
      if (last) tail.stream_end = 1;
      byte_q.push_back(tail);
    end
  endfunction

  assign pending = byte_q.size();

  initial begin
    errors = 0;
    clear_model();
  end

  // Watch both channels on the rising edge
  always @(posedge clk) begin
    packed_out_t exp_b;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (byte_q.size() == 0) begin
          $error("unexpected output transaction %h", m_tdata);
          errors++;
        end else begin
          exp_b = byte_q.pop_front();
          if (m_tdata !== exp_b.data) begin
            $error("packed_byte expected %h actual %h", exp_b.data, m_tdata);
            errors++;
          end
          if (m_tlast !== exp_b.run_last) begin
            $error("run_last expected %b actual %b", exp_b.run_last, m_tlast);
            errors++;
          end
          if (m_tuser !== exp_b.stream_end) begin
            $error("stream_end expected %b actual %b", exp_b.stream_end, m_tuser);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) compress_byte(s_tdata, s_tlast);
    end
  end
endmodule

// File: tb/lzw_hashed_compressor_tb.sv
// Testbench top for the LZW compressor: stimulus, reset and verdict.
`timescale 1ns / 1ps

module lzw_hashed_compressor_tb;
  logic       clk = 0;
  logic       rst = 1;
  logic       s_tvalid = 0;
  logic       s_tready;
  logic [7:0] s_tdata = 0;
  logic       s_tlast = 0;
  logic       m_tvalid;
  logic       m_tready = 0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       m_tuser;
  int         errors;
  int         pending;
  bit         hold_long = 0;

  always #10 clk = ~clk;

  lzw_hashed_compressor DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  lzw_hashed_compressor_chk CHK (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser), .errors(errors), .pending(pending)
  );

  // Send one byte, with a random gap first; ready is stable at the falling edge
  task automatic send_byte(bit [7:0] b, bit last);
    int gap;
    gap = $urandom_range(0, 4);
    repeat (gap) @(negedge clk);
    s_tvalid <= 1;
    s_tdata  <= b;
    s_tlast  <= last;
    while (!s_tready) @(negedge clk);
    @(negedge clk);
    s_tvalid <= 0;
  endtask

  // Receiver: random stalls, one long hold-off on request
  initial begin
    int w;
    @(negedge clk);
    forever begin
      if (hold_long) begin
        m_tready <= 0;
        repeat (300) @(negedge clk);
        hold_long = 0;
      end
      w = $urandom_range(0, 4);
      if (w > 0) begin
        m_tready <= 0;
        repeat (w) @(negedge clk);
      end
      m_tready <= 1;
      while (!m_tvalid) @(negedge clk);
      @(negedge clk);
    end
  end

  initial begin
    #200000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int len;
    int mode;
    int sent;
    bit [7:0] b;
    bit [7:0] alpha;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: single-byte stream, extremes, repeats that hit the dictionary
    send_byte(8'h00, 1);
    send_byte(8'hFF, 1);
    send_byte(8'h00, 0);
    send_byte(8'hFF, 0);
    for (int i = 0; i < 8; i++) send_byte(8'hAA, 0);
    for (int i = 0; i < 6; i++) send_byte(i[0] ? 8'h55 : 8'hAA, 0);
    send_byte(8'h00, 1);

    // Long receiver hold-off while the sender keeps offering bytes
    hold_long = 1;
    for (int i = 0; i < 20; i++) send_byte(8'($urandom_range(0, 255)), i == 19);

    // Random streams: mostly small alphabets for hits, some full-range noise
    sent = 0;
    while (sent < 220) begin
      len = $urandom_range(1, 40);
      mode = $urandom_range(0, 3);
      alpha = 8'($urandom_range(0, 255));
      for (int i = 0; i < len; i++) begin
        if (mode == 0) b = 8'($urandom_range(0, 255));
        else b = alpha ^ 8'($urandom_range(0, mode));
        send_byte(b, i == len - 1);
        sent++;
      end
    end

    while (pending != 0) @(posedge clk);
    repeat (6000) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

// File: lzw_hashed_compressor.f
rtl/core/lzwc_pkg.sv
rtl/core/lzwc_ctrl.sv
rtl/core/lzwc_dp.sv
rtl/core/lzw_hashed_compressor.sv
tb/lzw_hashed_compressor_chk.sv
tb/lzw_hashed_compressor_tb.sv
